// File: hdl/mt521_pkg.sv
`default_nettype none

package mt521_pkg;

	// Word and state geometry
	localparam int WORD_W          = 32;
	localparam int DEF_STATE_WORDS = 17;
	localparam int TWIST_OFFSET    = 8;
	localparam int LOWER_BITS      = 23;

	// Seeding recurrence
	localparam logic [WORD_W-1:0] SEED_MULT  = 32'd1812433253;
	localparam int                SEED_SHIFT = 30;

	// Tempering shifts
	localparam int TEMPER_R1 = 12;
	localparam int TEMPER_LB = 7;
	localparam int TEMPER_LC = 15;
	localparam int TEMPER_R2 = 18;

	// Split of a word into upper and lower parts for the twist
	localparam logic [WORD_W-1:0] LOW_MASK  = 32'((64'd1 << LOWER_BITS) - 64'd1);
	localparam logic [WORD_W-1:0] HIGH_MASK = ~LOW_MASK;

	// Configuration register indexes
	localparam int                 CFG_INDEX_W      = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_TWIST_MATRIX = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TEMPER_B     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TEMPER_C     = 2'd2;

	// Commands
	localparam logic CMD_RESEED = 1'b0;
	localparam logic CMD_NEXT   = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	// Temper one state word with the configured masks
	function automatic word_t temper(input word_t x_in, input word_t mask_b,
		input word_t mask_c);
		word_t x;
		x = x_in;
		x = x ^ (x >> TEMPER_R1);
		x = x ^ ((x << TEMPER_LB) & mask_b);
		x = x ^ ((x << TEMPER_LC) & mask_c);
		x = x ^ (x >> TEMPER_R2);
		return x;
	endfunction

endpackage

`default_nettype wire

// File: hdl/mt521_store.sv
`default_nettype none

module mt521_store #(
	parameter int DEPTH = mt521_pkg::DEF_STATE_WORDS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire mt521_pkg::word_t           wdata,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output mt521_pkg::word_t                rdata
);
	import mt521_pkg::*;

	word_t            mem [DEPTH];
	word_t            rd_q;
	logic [DEPTH-1:0] valid_q;
	logic             rd_vld_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// Track written entries; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_vld_q <= valid_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

// File: hdl/mersenne_twister_521_generator_unit.sv
`default_nettype none

// Next request: busy in the output read state (ST_OUT), then the result strobe is registered.
// A next request that finds the state used up first twists all words, each state word
//   in ST_TW_CUR, ST_TW_NXT and ST_TW_WR (read word, read neighbor, read far word and write).
// Reseed request: busy while it fills the state (multiplier then add per word), no result.
// The receiver cannot stall; a new request may be accepted while a result shows.
// Reset clears the control and configuration registers, makes the state words read as zero and marks a twist pending.
module mersenne_twister_521_generator_unit #(
	parameter int STATE_WORDS = mt521_pkg::DEF_STATE_WORDS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              command,
	input  wire mt521_pkg::word_t                  seed_value,
	output logic                                   done,
	output mt521_pkg::word_t                       random_word,
	input  wire logic                              cfg_write,
	input  wire logic [mt521_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire mt521_pkg::word_t                  cfg_data
);
	import mt521_pkg::*;

	localparam int AW      = $clog2(STATE_WORDS);
	localparam int PW      = $clog2(STATE_WORDS + 1);
	localparam int OFF_MOD = TWIST_OFFSET % STATE_WORDS;

	localparam logic [AW-1:0] LAST_IDX = AW'(STATE_WORDS - 1);
	localparam logic [PW-1:0] PENDING  = PW'(STATE_WORDS);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SEED_WR  = 3'd1;
	localparam logic [2:0] ST_SEED_ADD = 3'd2;
	localparam logic [2:0] ST_TW_CUR   = 3'd3;
	localparam logic [2:0] ST_TW_NXT   = 3'd4;
	localparam logic [2:0] ST_TW_WR    = 3'd5;
	localparam logic [2:0] ST_OUT      = 3'd6;

	logic [2:0]    state_q;
	logic [AW-1:0] idx_q;
	logic [PW-1:0] pos_q;
	word_t         seed_q;
	word_t         prod_q;
	word_t         cur_q;
	word_t         nxt_q;
	word_t         matrix_q;
	word_t         mask_b_q;
	word_t         mask_c_q;
	word_t         word_q;
	logic          done_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	word_t         mem_wdata;
	logic [AW-1:0] mem_raddr;
	word_t         mem_rdata;

	logic          accept;
	logic          idx_last;
	logic [AW-1:0] idx_next;
	logic [AW:0]   far_sum;
	logic [AW-1:0] far_idx;
	word_t         tw_y;
	word_t         tw_v;
	word_t         seed_mix;

	mt521_store #(
		.DEPTH(STATE_WORDS)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Index arithmetic: neighbor wraps to zero, far word wraps modulo the depth
	assign idx_last = (idx_q == LAST_IDX);
	assign idx_next = idx_last ? '0 : idx_q + AW'(1);
	assign far_sum  = {1'b0, idx_q} + (AW+1)'(OFF_MOD);
	assign far_idx  = (far_sum >= (AW+1)'(STATE_WORDS)) ?
		AW'(far_sum - (AW+1)'(STATE_WORDS)) : far_sum[AW-1:0];

	// Twist one word: far word arrives from memory in the write cycle
	assign tw_y = (cur_q & HIGH_MASK) | (nxt_q & LOW_MASK);
	assign tw_v = mem_rdata ^ (tw_y >> 1) ^ (tw_y[0] ? matrix_q : '0);

	assign seed_mix = seed_q ^ (seed_q >> SEED_SHIFT);

	// Memory access per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = tw_v;
		mem_raddr = (pos_q == PENDING) ? '0 : pos_q[AW-1:0];
		case (state_q)
			ST_SEED_WR: begin
				mem_we    = 1'b1;
				mem_wdata = seed_q;
			end
			ST_TW_CUR: begin
				mem_raddr = idx_next;
			end
			ST_TW_NXT: begin
				mem_raddr = far_idx;
			end
			ST_TW_WR: begin
				mem_we    = 1'b1;
				mem_raddr = idx_next;
			end
			default: begin
			end
		endcase
	end

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q <= '0;
			mask_b_q <= '0;
			mask_c_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TWIST_MATRIX: matrix_q <= cfg_data;
				REG_TEMPER_B:     mask_b_q <= cfg_data;
				REG_TEMPER_C:     mask_c_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer: seed fill, twist sweep and output read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			pos_q   <= PENDING;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (command == CMD_RESEED) begin
							pos_q   <= PENDING;
							state_q <= ST_SEED_WR;
						end else if (pos_q == PENDING) begin
							state_q <= ST_TW_CUR;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_SEED_WR: begin
					state_q <= idx_last ? ST_IDLE : ST_SEED_ADD;
				end
				ST_SEED_ADD: begin
					idx_q   <= idx_q + AW'(1);
					state_q <= ST_SEED_WR;
				end
				ST_TW_CUR: begin
					state_q <= ST_TW_NXT;
				end
				ST_TW_NXT: begin
					state_q <= ST_TW_WR;
				end
				ST_TW_WR: begin
					idx_q <= idx_next;
					if (idx_last) begin
						pos_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_TW_CUR;
					end
				end
				ST_OUT: begin
					pos_q   <= pos_q + PW'(1);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept && command == CMD_RESEED) begin
			seed_q <= seed_value;
		end else if (state_q == ST_SEED_ADD) begin
			seed_q <= prod_q + WORD_W'(idx_q) + WORD_W'(1);
		end
		if (state_q == ST_SEED_WR) begin
			prod_q <= SEED_MULT * seed_mix;
		end
		if (state_q == ST_TW_CUR) begin
			cur_q <= mem_rdata;
		end
		if (state_q == ST_TW_NXT) begin
			nxt_q <= mem_rdata;
		end
		if (state_q == ST_OUT) begin
			word_q <= temper(mem_rdata, mask_b_q, mask_c_q);
		end
	end

	assign done        = done_q;
	assign random_word = word_q;

`ifndef SYNTHESIS
	// A result follows only the output read cycle
	a_done_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_OUT))
		else $error("result strobe without output read");

	// Read position never passes the pending mark
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PENDING)
		else $error("read position out of range");

	// A next request on used-up state starts a twist sweep at word zero
	a_twist_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_NEXT && pos_q == PENDING)
		|=> (state_q == ST_TW_CUR && idx_q == '0))
		else $error("twist did not start");

	// Output read never sees a pending position
	a_out_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (pos_q != PENDING))
		else $error("output read with twist pending");

	// Sweep index stays inside the state
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (idx_q <= LAST_IDX))
		else $error("sweep index out of range");
`endif

endmodule

`default_nettype wire

// File: test/mt521_stream_monitor.sv
`timescale 1ns / 100ps

module mt521_stream_monitor #(
	parameter int STATE_WORDS = mt521_pkg::DEF_STATE_WORDS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic                              busy,
	input  wire logic                              command,
	input  wire mt521_pkg::word_t                  seed_value,
	input  wire logic                              done,
	input  wire mt521_pkg::word_t                  random_word,
	input  wire logic                              cfg_write,
	input  wire logic [mt521_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire mt521_pkg::word_t                  cfg_data,
	output int                                     mismatches,
	output int                                     words_owed
);
	import mt521_pkg::*;

	// Shadow copy of the generator
	word_t       gen_words [STATE_WORDS];
	int unsigned gen_pos;
	word_t       matrix_word;
	word_t       mask_b;
	word_t       mask_c;

	// Predicted output words, oldest first
	word_t       expected_words [$];

	// Fill the state with the multiplier recurrence
	function automatic void reseed_state(input word_t seed);
		word_t w;
		w = seed;
		for (int i = 0; i < STATE_WORDS; i++) begin
			gen_words[i] = w;
			w = SEED_MULT * (w ^ (w >> SEED_SHIFT)) + word_t'(i + 1);
		end
		gen_pos = STATE_WORDS;
	endfunction

	// Regenerate every word in place
	function automatic void twist_state();
		word_t y;
		word_t v;
		for (int k = 0; k < STATE_WORDS; k++) begin
			y = (gen_words[k] & HIGH_MASK) | (gen_words[(k + 1) % STATE_WORDS] & LOW_MASK);
			v = gen_words[(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1);
			if (y[0])
				v = v ^ matrix_word;
			gen_words[k] = v;
		end
		gen_pos = 0;
	endfunction

	function automatic word_t temper_word(input word_t raw);
		word_t t;
		t = raw;
		t = t ^ (t >> 12);
		t = t ^ ((t << 7) & mask_b);
		t = t ^ ((t << 15) & mask_c);
		t = t ^ (t >> 18);
		return t;
	endfunction

	function automatic word_t next_word();
		word_t r;
		if (gen_pos >= STATE_WORDS)
			twist_state();
		r = temper_word(gen_words[gen_pos]);
		gen_pos++;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_t want;
		if (!arst_n) begin
			for (int i = 0; i < STATE_WORDS; i++)
				gen_words[i] = '0;
			gen_pos     = STATE_WORDS;
			matrix_word = '0;
			mask_b      = '0;
			mask_c      = '0;
			expected_words.delete();
			mismatches  = 0;
			words_owed  = 0;
		end else begin
			// Check a delivered word against the oldest prediction
			if (done) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected random_word: expected none, got %08h",
						$time, random_word);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (random_word !== want) begin
						$display("%0t: random_word expected %08h, got %08h",
							$time, want, random_word);
						mismatches++;
					end
				end
			end
			// Predict the outcome of an accepted request
			if (start && !busy) begin
				if (command == CMD_RESEED)
					reseed_state(seed_value);
				else
					expected_words.push_back(next_word());
			end
			// Track register writes; the unused index is dropped
			if (cfg_write) begin
				case (cfg_index)
					REG_TWIST_MATRIX: matrix_word = cfg_data;
					REG_TEMPER_B:     mask_b      = cfg_data;
					REG_TEMPER_C:     mask_c      = cfg_data;
					default: ;
				endcase
			end
			words_owed = expected_words.size();
		end
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import mt521_pkg::*;

	localparam int                     GEN_WORDS    = DEF_STATE_WORDS;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED   = 2'd3;
	localparam int                     PHASES       = 6;
	localparam int                     PHASE_ITEMS  = 225;
	localparam int                     SETTLE_TICKS = 2 * GEN_WORDS + 8;
	localparam int                     CYCLE_LIMIT  = 400000;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic                   command;
	word_t                  seed_value;
	logic                   done;
	word_t                  random_word;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	word_t                  cfg_data;
	int                     mismatches;
	int                     words_owed;
	int                     cycle_count;
	bit                     steady_run;

	mersenne_twister_521_generator_unit #(.STATE_WORDS(GEN_WORDS)) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.seed_value  (seed_value),
		.done        (done),
		.random_word (random_word),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	mt521_stream_monitor #(.STATE_WORDS(GEN_WORDS)) monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.seed_value  (seed_value),
		.done        (done),
		.random_word (random_word),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.words_owed  (words_owed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Abort a hung run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Present one request and hold it until accepted; returns at a falling edge
	task automatic issue(input logic cmd, input word_t seed);
		start      <= 1'b1;
		command    <= cmd;
		seed_value <= seed;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// Idle between requests: mostly short gaps, a few long ones
	task automatic idle_gap();
		int roll;
		int ticks;
		roll = $urandom_range(0, 99);
		if (steady_run || roll < 50)
			ticks = 0;
		else if (roll < 85)
			ticks = $urandom_range(1, 3);
		else if (roll < 97)
			ticks = $urandom_range(4, 12);
		else
			ticks = $urandom_range(20, 60);
		if (ticks > 0) begin
			start      <= 1'b0;
			command    <= 1'($urandom);
			seed_value <= $urandom;
			repeat (ticks) @(negedge clk);
		end
	endtask

	// Wait for every predicted word, then let a trailing reseed finish
	task automatic drain();
		start <= 1'b0;
		while (words_owed != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	// Write one register; caller lowers the enable after the last write
	task automatic reg_put(input logic [CFG_INDEX_W-1:0] idx, input word_t val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	task automatic load_settings(input word_t mtx, input word_t mb, input word_t mc);
		reg_put(REG_TWIST_MATRIX, mtx);
		reg_put(REG_TEMPER_B, mb);
		reg_put(REG_TEMPER_C, mc);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		word_t seed;
		start      = 1'b0;
		command    = CMD_NEXT;
		seed_value = '0;
		cfg_write  = 1'b0;
		cfg_index  = REG_TWIST_MATRIX;
		cfg_data   = '0;
		steady_run = 1'b0;
		arst_n     = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: unseeded output, both extreme seeds, twist boundary
		reg_put(REG_UNUSED, 32'hFFFF_FFFF);
		load_settings(32'h9908_B0DF, 32'h9D2C_5680, 32'hEFC6_0000);
		issue(CMD_NEXT, 32'hFFFF_FFFF);
		issue(CMD_NEXT, '0);
		issue(CMD_RESEED, '0);
		for (int i = 0; i < 18; i++) begin
			issue(CMD_NEXT, $urandom);
			idle_gap();
		end
		issue(CMD_RESEED, 32'hFFFF_FFFF);
		issue(CMD_NEXT, '0);
		issue(CMD_NEXT, '0);

		// Random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: load_settings('0, '0, '0);
				1: load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: load_settings($urandom, $urandom, $urandom);
				3: load_settings(32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
				4: load_settings('0, 32'hFFFF_FFFF, $urandom);
				default: load_settings($urandom, $urandom, $urandom);
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Toggle between gapped and back-to-back stretches
				if ($urandom_range(0, 49) == 0)
					steady_run = ~steady_run;
				// Hold off once until every word has been delivered
				if (p == 2 && n == PHASE_ITEMS / 2)
					drain();
				if ($urandom_range(0, 39) == 0) begin
					case ($urandom_range(0, 7))
						0:       seed = '0;
						1:       seed = 32'hFFFF_FFFF;
						default: seed = $urandom;
					endcase
					issue(CMD_RESEED, seed);
				end else begin
					issue(CMD_NEXT, $urandom);
				end
				idle_gap();
			end
		end

		drain();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: filelist.f
hdl/mt521_pkg.sv
hdl/mt521_store.sv
hdl/mersenne_twister_521_generator_unit.sv
test/mt521_stream_monitor.sv
test/testbench.sv
